// ----- sv/balanced_tree_separator_select_macros.svh -----
// Assertion macros shared by the separator select RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BALANCED_TREE_SEPARATOR_SELECT_MACROS_SVH
`define BALANCED_TREE_SEPARATOR_SELECT_MACROS_SVH

// same-cycle implication
`define BTSS_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTSS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/btss_pkg.sv -----
// Package for the separator select block: payload types, cell links, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btss_pkg;

	localparam int VAL_W      = 32;
	localparam int BUDGET_W   = 6;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic REG_LEVEL_BUDGET = 1'b0;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] separator;
		logic                    last_separator;
	} sep_item_t;

	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
	} cell_link_t;

	typedef struct packed {
		logic ins;
		logic shift;
		logic clr;
	} cell_ctl_t;

	typedef struct packed {
		logic rank_vld;
		logic done;
	} rg_stat_t;

	typedef enum logic [1:0] {
		RG_IDLE,
		RG_WALK,
		RG_EMIT,
		RG_DONE
	} rg_state_t;

	typedef enum logic {
		PH_LOAD,
		PH_SEL
	} ph_state_t;

endpackage

`default_nettype wire

// ----- sv/balanced_tree_separator_select.sv -----
// Top level of the separator select block: APB register, sorting cell row,
// rank sequencer and output stage. Depends on btss_pkg, btss_cell, btss_rank_gen.
//
// While loading, the block takes one data transfer per clock and inserts each value
// into a row of MAX_ITEMS sorting cells, so the row is always in ascending order;
// values past MAX_ITEMS are dropped. The transfer marked last closes the set and the
// input stalls until every separator has been handed on. During selection the rank
// sequencer visits one tree node per clock while no separator waits to be taken (at
// most 2^L - 1 separators for a budget of bit length L, so 63 at most); while a rank
// is offered the row shifts one value per clock toward its head, unless the head holds
// that rank and output stalls keep it from being taken. The row is cleared at the end;
// there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "balanced_tree_separator_select_macros.svh"

module balanced_tree_separator_select #(
	parameter int MAX_ITEMS  = 1024,
	parameter int MAX_LEVELS = 6
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [btss_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire [btss_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [btss_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  wire                                 data_valid,
	output logic                                data_stall,
	input  wire btss_pkg::in_item_t             data,
	output logic                                result_valid,
	input  wire                                 result_stall,
	output btss_pkg::sep_item_t                 result
);
	import btss_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	ph_state_t phase_q, phase_nx;

	logic [BUDGET_W-1:0] budget_q;
	logic [CW-1:0]       cnt_q, cnt_inc;
	logic [CW-1:0]       pos_q;
	logic                pend_vld_q;
	logic signed [VAL_W-1:0] pend_val_q;
	logic                out_vld_q;
	sep_item_t           out_q;

	logic        reg_idx;
	logic        cfg_wr;
	logic        acc;
	logic        full;
	logic        start;
	logic        hit, take, pend_free, pend_move, set_done;
	cell_ctl_t   cctl;
	rg_stat_t    rstat;
	logic [CW-1:0] rank;

	cell_link_t links [MAX_ITEMS];
	logic       gts   [MAX_ITEMS];

	// configuration port
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_LEVEL_BUDGET: prdata = {{(APB_DATA_W-BUDGET_W){1'b0}}, budget_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_wr && reg_idx == REG_LEVEL_BUDGET) begin
			budget_q <= pwdata[BUDGET_W-1:0];
		end
	end

	// load side
	assign data_stall = (phase_q != PH_LOAD);
	assign acc     = data_valid && !data_stall;
	assign full    = (cnt_q == CW'(MAX_ITEMS));
	assign cnt_inc = full ? cnt_q : cnt_q + CW'(1);
	assign start   = acc && data.last_value;

	// selection side
	assign hit       = rstat.rank_vld && (rank == pos_q);
	assign pend_move = pend_vld_q && (!out_vld_q || !result_stall)
		&& (rstat.rank_vld || rstat.done);
	assign pend_free = !pend_vld_q || pend_move;
	assign take      = hit && pend_free;

	always_comb begin
		phase_nx = phase_q;
		unique case (phase_q)
			PH_LOAD: if (start) phase_nx = PH_SEL;
			PH_SEL:  if (set_done) phase_nx = PH_LOAD;
			default: phase_nx = PH_LOAD;
		endcase
	end

	always_comb begin
		set_done   = (phase_q == PH_SEL) && rstat.done && !pend_vld_q;
		cctl.ins   = acc && !full;
		cctl.shift = (phase_q == PH_SEL) && rstat.rank_vld && (!hit || take);
		cctl.clr   = set_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LOAD;
			cnt_q      <= '0;
			pos_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			if (acc) begin
				cnt_q <= data.last_value ? '0 : cnt_inc;
			end
			if (start) begin
				pos_q <= '0;
			end else if (cctl.shift) begin
				pos_q <= pos_q + CW'(1);
			end
			pend_vld_q <= take || (pend_vld_q && !pend_move);
			out_vld_q  <= pend_move || (out_vld_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_val_q <= links[0].val;
		end
		if (pend_move) begin
			out_q <= '{separator: pend_val_q, last_separator: rstat.done};
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		cell_link_t left_l, right_l;
		logic       left_gt;
		if (i == 0) begin : g_head
			assign left_l  = '0;
			assign left_gt = 1'b0;
		end else begin : g_body
			assign left_l  = links[i-1];
			assign left_gt = gts[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_l = '0;
		end else begin : g_mid
			assign right_l = links[i+1];
		end
		btss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cctl),
			.new_val (data.value),
			.left    (left_l),
			.left_gt (left_gt),
			.right   (right_l),
			.own     (links[i]),
			.gt      (gts[i])
		);
	end

	btss_rank_gen #(
		.MAX_ITEMS  (MAX_ITEMS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_rank_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.n      (cnt_inc),
		.k      (budget_q),
		.take   (take),
		.rank   (rank),
		.stat   (rstat)
	);

	`BTSS_IMPLIES(a_shift_valid_head, cctl.shift, links[0].vld, "shift with empty head cell")
	`BTSS_IMPLIES(a_take_valid_head, take, links[0].vld, "separator taken from empty cell")
	`BTSS_IMPLIES(a_no_pend_in_load, phase_q == PH_LOAD, !pend_vld_q, "separator left pending")
	`BTSS_NEXT(a_move_fills_out, pend_move, result_valid, "moved separator not presented")

endmodule

`default_nettype wire

// ----- sv/btss_cell.sv -----
// One cell of the sorting row: holds a value, inserts in order, shifts toward cell 0.
// Depends on btss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btss_cell (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire btss_pkg::cell_ctl_t         ctl,
	input  wire signed [btss_pkg::VAL_W-1:0] new_val,
	input  wire btss_pkg::cell_link_t        left,
	input  wire                              left_gt,
	input  wire btss_pkg::cell_link_t        right,
	output btss_pkg::cell_link_t             own,
	output logic                             gt
);
	import btss_pkg::*;

	logic                    vld_q;
	logic signed [VAL_W-1:0] val_q;

	// invalid cells act as +infinity
	assign gt  = !vld_q || (val_q > new_val);
	assign own = '{vld: vld_q, val: val_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= right.vld;
		end else if (ctl.ins) begin
			if (left_gt) begin
				vld_q <= left.vld;
			end else if (gt) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right.val;
		end else if (ctl.ins) begin
			if (left_gt) begin
				val_q <= left.val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/btss_rank_gen.sv -----
// Rank sequencer: in-order walk of the split tree with a small stack, one node per cycle
// unless a rank waits to be taken. Depends on btss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "balanced_tree_separator_select_macros.svh"

module btss_rank_gen #(
	parameter int MAX_ITEMS  = 1024,
	parameter int MAX_LEVELS = 6,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int LW = $clog2(MAX_LEVELS + 1),
	localparam int SW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [CW-1:0]                  n,
	input  wire [btss_pkg::BUDGET_W-1:0]  k,
	input  wire                           take,
	output logic [CW-1:0]                 rank,
	output btss_pkg::rg_stat_t            stat
);
	import btss_pkg::*;

	rg_state_t state_q, state_nx;

	logic [CW-1:0]       lo_q, hi_q;
	logic [BUDGET_W-1:0] k_q;
	logic [LW-1:0]       lv_q;
	logic [LW-1:0]       sp_q;

	logic [CW-1:0]       stk_mid [MAX_LEVELS];
	logic [CW-1:0]       stk_hi  [MAX_LEVELS];
	logic [BUDGET_W-1:0] stk_k   [MAX_LEVELS];
	logic [LW-1:0]       stk_lv  [MAX_LEVELS];

	logic          node_ok;
	logic [CW:0]   sum;
	logic [CW-1:0] mid;
	logic [LW-1:0] sp_m1;
	logic [SW-1:0] top_idx;
	logic [SW-1:0] push_idx;
	logic          can_start;

	assign node_ok   = (k_q != '0) && (lo_q < hi_q) && (lv_q < LW'(MAX_LEVELS));
	assign sum       = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid       = sum[CW:1];
	assign sp_m1     = sp_q - LW'(1);
	assign top_idx   = sp_m1[SW-1:0];
	assign push_idx  = sp_q[SW-1:0];
	assign can_start = (state_q == RG_IDLE) || (state_q == RG_DONE);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			RG_IDLE, RG_DONE: begin
				if (start) begin
					state_nx = RG_WALK;
				end
			end
			RG_WALK: begin
				if (!node_ok) begin
					state_nx = (sp_q == '0) ? RG_DONE : RG_EMIT;
				end
			end
			RG_EMIT: begin
				if (take) begin
					state_nx = RG_WALK;
				end
			end
			default: state_nx = RG_IDLE;
		endcase
	end

	always_comb begin
		stat.rank_vld = (state_q == RG_EMIT);
		stat.done     = (state_q == RG_DONE);
		rank          = stk_mid[top_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RG_IDLE;
			sp_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (can_start && start) begin
				sp_q <= '0;
			end else if (state_q == RG_WALK && node_ok) begin
				sp_q <= sp_q + LW'(1);
			end else if (state_q == RG_EMIT && take) begin
				sp_q <= sp_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_start && start) begin
			lo_q <= '0;
			hi_q <= n;
			k_q  <= k;
			lv_q <= '0;
		end else if (state_q == RG_WALK && node_ok) begin
			// save right child, descend left
			stk_mid[push_idx] <= mid;
			stk_hi[push_idx]  <= hi_q;
			stk_k[push_idx]   <= k_q >> 1;
			stk_lv[push_idx]  <= lv_q + LW'(1);
			hi_q <= mid;
			k_q  <= k_q >> 1;
			lv_q <= lv_q + LW'(1);
		end else if (state_q == RG_EMIT && take) begin
			lo_q <= stk_mid[top_idx] + CW'(1);
			hi_q <= stk_hi[top_idx];
			k_q  <= stk_k[top_idx];
			lv_q <= stk_lv[top_idx];
		end
	end

	`BTSS_IMPLIES(a_rank_in_range, stat.rank_vld, rank < stk_hi[top_idx], "rank beyond its subrange")
	`BTSS_IMPLIES(a_emit_has_stack, stat.rank_vld, sp_q != '0, "rank offered with empty stack")
	`BTSS_NEXT(a_pop_depth, stat.rank_vld && take, sp_q == $past(sp_q) - LW'(1), "pop lost depth")

endmodule

`default_nettype wire
